// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ----- sv/pbsl_pkg.sv -----
// ----------------------------------------------------------------------------
// pbsl_pkg
// types and constants of the page bitmap slot locator
// ----------------------------------------------------------------------------
`default_nettype none

package pbsl_pkg;

    localparam int PAGE_W     = 64;  // page number width
    localparam int PS_W       = 17;  // page size register width
    localparam int IDW_W      = 4;   // id width register width
    localparam int REM_W      = 20;  // group length page bytes*8+1 fits here
    localparam int BITPOS_W   = 19;
    localparam int NUM_CELLS  = PAGE_W;  // one page bit per cell
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_DATA_W = 104;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_WIDTH   = 1'b1;

    localparam logic [PS_W-1:0]  PAGE_BYTES_RST = 17'd4096;
    localparam logic [IDW_W-1:0] ID_WIDTH_RST   = 4'd8;

    // one page number in flight with its partial remainder
    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [PAGE_W-1:0] page;
    } t_stage;

endpackage

`default_nettype wire

// ----- sv/pbsl_cell.sv -----
// ----------------------------------------------------------------------------
// pbsl_cell
// one restoring division step: shifts in one page bit, subtracts the group length
// ----------------------------------------------------------------------------
`default_nettype none

module pbsl_cell
    import pbsl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [REM_W-1:0] i_divisor,
    input  wire t_stage           i_stage,
    input  wire logic             i_bit,
    input  wire logic             i_down_ready,
    output logic                  o_ready,
    output t_stage                o_stage
);

    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [PAGE_W-1:0] r_page;

    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic [REM_W-1:0]  n_rem;

    // cell takes a new entry when empty or when its entry moves on
    assign o_ready = !r_valid || i_down_ready;

    assign trial = {i_stage.rem, i_bit};
    assign diff  = trial - {1'b0, i_divisor};
    assign n_rem = (trial >= {1'b0, i_divisor}) ? diff[REM_W-1:0] : trial[REM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem  <= n_rem;
            r_page <= i_stage.page;
        end
    end

    assign o_stage = '{valid: r_valid, rem: r_rem, page: r_page};

endmodule

`default_nettype wire

// ----- sv/pbsl_out.sv -----
// ----------------------------------------------------------------------------
// pbsl_out
// forms the result fields from the final remainder and holds the result transaction
// ----------------------------------------------------------------------------
`default_nettype none

module pbsl_out
    import pbsl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [PS_W-1:0]       i_page_bytes,
    input  wire logic [IDW_W-1:0]      i_id_width,
    input  wire t_stage                i_stage,
    output logic                       o_ready,
    output logic                       o_tvalid,
    input  wire logic                  i_tready,
    output logic [OUT_DATA_W-1:0]      o_tdata,
    output logic                       o_tuser
);

    logic                  r_valid;
    logic                  r_is_bitmap;
    logic [PAGE_W-1:0]     r_bitmap_page;
    logic [BITPOS_W-1:0]   r_bit_pos;
    logic [IDW_W-1:0]      r_header;
    logic [PS_W-1:0]       r_content;

    logic                  is_bitmap;
    logic [REM_W-1:0]      rem_m1;
    logic [IDW_W-1:0]      header;
    logic [PS_W-1:0]       hdr_ext;

    assign o_ready = !r_valid || i_tready;

    assign is_bitmap = (i_stage.rem == '0);
    assign rem_m1    = i_stage.rem - REM_W'(1);
    assign header    = is_bitmap ? '0 : i_id_width;
    assign hdr_ext   = {{(PS_W-IDW_W){1'b0}}, header};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_is_bitmap   <= is_bitmap;
            r_bitmap_page <= i_stage.page - {{(PAGE_W-REM_W){1'b0}}, i_stage.rem};
            r_bit_pos     <= is_bitmap ? '0 : rem_m1[BITPOS_W-1:0];
            r_header      <= header;
            r_content     <= (i_page_bytes > hdr_ext) ? (i_page_bytes - hdr_ext) : '0;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_is_bitmap;
    assign o_tdata  = {r_content, r_header, r_bit_pos, r_bitmap_page};

endmodule

`default_nettype wire

// ----- sv/page_bitmap_slot_locator.sv -----
// ----------------------------------------------------------------------------
// page_bitmap_slot_locator
// classifies a page number against bitmap groups of page bytes*8+1 pages
// ----------------------------------------------------------------------------
// channel   dir  signals                      content
// s         in   i_s_tvalid/o_s_tready        page number, one per transaction
// m         out  o_m_tvalid/i_m_tready        bitmap flag, bitmap page, bit, sizes
// cfg       in   i_cfg_we/i_cfg_addr          page size, id width
//
// one transaction accepted per cycle while the chain has room, one result per transaction
// a page number passes 64 division cells, one page bit each, then the result register
// the division chain and the result register set the latency; each cell holds one transaction
// a stall on m fills empty cells first, so input keeps flowing until the chain is full
// reset clears the valid bits and loads page size 4096 and id width 8
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module page_bitmap_slot_locator
    import pbsl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave side
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [PAGE_W-1:0]     i_s_tdata,   // [63:0] page_number
    // master side
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [63:0] bitmap_page_number, [82:64] bit_position,
    // [86:83] header_bytes, [103:87] content_bytes
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic                       o_m_tuser,   // [0] is_bitmap_page
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [PS_W-1:0]       i_cfg_wdata
);

    // configuration registers
    logic [PS_W-1:0]  r_page_bytes;
    logic [IDW_W-1:0] r_id_width;
    logic [REM_W-1:0] divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= PAGE_BYTES_RST;
            r_id_width   <= ID_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PAGE_BYTES: r_page_bytes <= i_cfg_wdata;
                CFG_ID_WIDTH:   r_id_width   <= i_cfg_wdata[IDW_W-1:0];
                default:        r_page_bytes <= r_page_bytes;
            endcase
        end
    end

    // group length, low three bits of the shifted size are zero so +1 never carries
    assign divisor = {r_page_bytes, 3'b000} | REM_W'(1);

    // division chain, stage k carries the remainder of the top k page bits
    t_stage stage [0:NUM_CELLS];
    logic   rdy   [0:NUM_CELLS];

    assign stage[0]   = '{valid: i_s_tvalid, rem: '0, page: i_s_tdata};
    assign o_s_tready = rdy[0];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        pbsl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_divisor    (divisor),
            .i_stage      (stage[k]),
            .i_bit        (stage[k].page[PAGE_W-1-k]),
            .i_down_ready (rdy[k+1]),
            .o_ready      (rdy[k]),
            .o_stage      (stage[k+1])
        );
    end

    // result register on the master side
    pbsl_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_page_bytes (r_page_bytes),
        .i_id_width   (r_id_width),
        .i_stage      (stage[NUM_CELLS]),
        .o_ready      (rdy[NUM_CELLS]),
        .o_tvalid     (o_m_tvalid),
        .i_tready     (i_m_tready),
        .o_tdata      (o_m_tdata),
        .o_tuser      (o_m_tuser)
    );

    // final remainder is always reduced below the group length
    `ASSERT_IMPL(a_rem_ok, stage[NUM_CELLS].valid, stage[NUM_CELLS].rem < divisor, "rem too big")

    // a bitmap page carries no header and bit zero
    `ASSERT_IMPL(a_bitmap_zero, o_m_tvalid && o_m_tuser, o_m_tdata[86:64] == '0, "bad bitmap")

    // an accepted transaction lands in the first cell
    `ASSERT_CLK(a_first_cell, (i_s_tvalid && o_s_tready) |=> stage[1].valid, "lost at entry")

endmodule

`default_nettype wire
